// ===== hdl/round_robin_completion_times_defines.svh =====
// Assertion macros shared by the round-robin completion-time RTL.
`ifndef ROUND_ROBIN_COMPLETION_TIMES_DEFINES_SVH
`define ROUND_ROBIN_COMPLETION_TIMES_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define RRCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rrct assertion failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define RRCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rrct assertion failed");

`endif

// ===== hdl/rrct_pkg.sv =====
// Package: sizes and the job record for the round-robin completion-time block.
`timescale 1ns / 1ps
package rrct_pkg;

    localparam int MAX_JOBS    = 32;
    localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W       = $clog2(MAX_JOBS + 1);
    localparam int BURST_W     = 16;
    localparam int QUANTUM_W   = 16;
    localparam int TIME_W      = 21;
    localparam int JOB_INDEX_W = 5;

    // One job as it travels around the ring.
    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
    } job_t;

endpackage

// ===== hdl/round_robin_completion_times.sv =====
// Top level: round-robin completion-time block, job ring plus service stage.
`timescale 1ns / 1ps
`include "round_robin_completion_times_defines.svh"
// Round-robin completion times. Jobs arrive one burst per beat on the s_
// channel, one per cycle while s_ready is high; s_last closes the set. Zero
// bursts and bursts past MAX_JOBS are dropped (their s_last still counts).
// The jobs sit in a ring of MAX_JOBS cells that rotates one cell per cycle,
// unless the m_ channel stalls a finished job, through the service stage at
// its head, so every visit of a job and every pass over an empty cell is one
// shift of the ring. A result beat goes out for each job as it completes, in
// completion order, and m_final_res marks the last one. s_ready stays low
// from the closing beat until the last result has been computed; the next
// set may load while that beat still waits on m_ready. cfg_quantum must be
// written only while idle; the block itself does not enforce it. Zero acts as one.
module round_robin_completion_times (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrct_pkg::QUANTUM_W-1:0]   cfg_quantum,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rrct_pkg::BURST_W-1:0]     s_burst_time,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rrct_pkg::JOB_INDEX_W-1:0] m_job_index,
    output logic [rrct_pkg::TIME_W-1:0]      m_turnaround,
    output logic [rrct_pkg::TIME_W-1:0]      m_waiting,
    output logic                             m_final_res
);

    typedef enum logic {
        ST_LOAD,
        ST_SIM
    } state_t;

    state_t                         state_reg;
    logic [rrct_pkg::CNT_W-1:0]     job_count_reg;
    logic [rrct_pkg::QUANTUM_W-1:0] quantum_reg;

    logic                           in_beat;
    logic                           store_en;
    logic                           step;
    logic                           set_done;
    logic                           shift_en;
    logic [rrct_pkg::QUANTUM_W-1:0] q_eff;
    rrct_pkg::job_t                 new_job;
    rrct_pkg::job_t                 served;
    rrct_pkg::job_t                 tail_in;
    rrct_pkg::job_t                 ring [rrct_pkg::MAX_JOBS];

    // config: always ready, one register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= rrct_pkg::QUANTUM_W'(1);
        end else if (cfg_valid) begin
            quantum_reg <= cfg_quantum;
        end
    end

    assign q_eff = (quantum_reg == '0) ? rrct_pkg::QUANTUM_W'(1) : quantum_reg;

    // input side
    assign s_ready  = (state_reg == ST_LOAD);
    assign in_beat  = s_valid && s_ready;
    assign store_en = in_beat && (s_burst_time != '0)
                   && (job_count_reg < rrct_pkg::CNT_W'(rrct_pkg::MAX_JOBS));

    assign new_job.vld   = 1'b1;
    assign new_job.idx   = rrct_pkg::IDX_W'(job_count_reg);
    assign new_job.burst = s_burst_time;
    assign new_job.rem   = s_burst_time;

    // Loading pushes into the tail; during a set the head's job comes back
    // in at the tail after its slice, so the ring order is the visit order.
    assign tail_in  = (state_reg == ST_SIM) ? served : new_job;
    assign shift_en = store_en || ((state_reg == ST_SIM) && step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            job_count_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (store_en) begin
                        job_count_reg <= job_count_reg + rrct_pkg::CNT_W'(1);
                    end
                    if (in_beat && s_last) begin
                        if (store_en || (job_count_reg != '0)) begin
                            state_reg <= ST_SIM;
                        end
                    end
                end
                ST_SIM: begin
                    if (set_done) begin
                        state_reg     <= ST_LOAD;
                        job_count_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // cell k takes from cell k+1; the last cell takes the tail input
    for (genvar k = 0; k < rrct_pkg::MAX_JOBS; k++) begin : g_ring
        rrct_pkg::job_t cell_in;
        if (k == rrct_pkg::MAX_JOBS - 1) begin : g_tail
            assign cell_in = tail_in;
        end else begin : g_mid
            assign cell_in = ring[k+1];
        end
        rrct_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .clear    (set_done),
            .job_in   (cell_in),
            .job_out  (ring[k])
        );
    end

    rrct_serve u_serve (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active       (state_reg == ST_SIM),
        .quantum      (q_eff),
        .job_count    (job_count_reg),
        .head         (ring[0]),
        .served       (served),
        .step         (step),
        .set_done     (set_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_job_index  (m_job_index),
        .m_turnaround (m_turnaround),
        .m_waiting    (m_waiting),
        .m_final_res  (m_final_res)
    );

    `RRCT_ASSERT_NOW(a_count_bound, 1'b1, job_count_reg <= rrct_pkg::CNT_W'(rrct_pkg::MAX_JOBS))
    `RRCT_ASSERT_NOW(a_sim_nonempty, state_reg == ST_SIM, job_count_reg != '0)
    `RRCT_ASSERT_NEXT(a_final_marked, set_done, m_valid && m_final_res)
    `RRCT_ASSERT_NEXT(a_done_reopens, set_done, s_ready && (job_count_reg == '0))

endmodule

// ===== hdl/rrct_cell.sv =====
// Ring cell: holds one job and takes its neighbor's job on each shift.
`timescale 1ns / 1ps
module rrct_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic          clear,
    input  rrct_pkg::job_t job_in,
    output rrct_pkg::job_t job_out
);

    logic                        vld_reg;
    logic [rrct_pkg::IDX_W-1:0]   idx_reg;
    logic [rrct_pkg::BURST_W-1:0] burst_reg;
    logic [rrct_pkg::BURST_W-1:0] rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (clear) begin
            vld_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg <= job_in.vld;
        end
        // payload needs no reset, vld guards it
        if (shift_en) begin
            idx_reg   <= job_in.idx;
            burst_reg <= job_in.burst;
            rem_reg   <= job_in.rem;
        end
    end

    assign job_out.vld   = vld_reg;
    assign job_out.idx   = idx_reg;
    assign job_out.burst = burst_reg;
    assign job_out.rem   = rem_reg;

endmodule

// ===== hdl/rrct_serve.sv =====
// Service stage at the ring head: runs one slice, keeps the clock, holds the result beat.
`timescale 1ns / 1ps
`include "round_robin_completion_times_defines.svh"
module rrct_serve (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             active,
    input  logic [rrct_pkg::QUANTUM_W-1:0]   quantum,
    input  logic [rrct_pkg::CNT_W-1:0]       job_count,
    input  rrct_pkg::job_t                   head,
    output rrct_pkg::job_t                   served,
    output logic                             step,
    output logic                             set_done,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rrct_pkg::JOB_INDEX_W-1:0] m_job_index,
    output logic [rrct_pkg::TIME_W-1:0]      m_turnaround,
    output logic [rrct_pkg::TIME_W-1:0]      m_waiting,
    output logic                             m_final_res
);

    logic [rrct_pkg::TIME_W-1:0]      sim_time_reg;
    logic [rrct_pkg::CNT_W-1:0]       done_count_reg;
    logic                             m_valid_reg;
    logic [rrct_pkg::JOB_INDEX_W-1:0] job_index_reg;
    logic [rrct_pkg::TIME_W-1:0]      turnaround_reg;
    logic [rrct_pkg::TIME_W-1:0]      waiting_reg;
    logic                             final_reg;

    logic                             live;
    logic                             fin;
    logic                             out_free;
    logic                             last_one;
    logic [rrct_pkg::BURST_W-1:0]     slice;
    logic [rrct_pkg::TIME_W-1:0]      sim_time_next;
    logic [rrct_pkg::TIME_W-1:0]      waiting_next;

    assign live     = head.vld && (head.rem != '0);
    assign fin      = live && (head.rem <= quantum);
    assign out_free = !m_valid_reg || m_ready;
    assign step     = active && (!fin || out_free);
    assign last_one = (done_count_reg + rrct_pkg::CNT_W'(1)) == job_count;
    assign set_done = step && fin && last_one;

    assign slice         = fin ? head.rem : quantum;
    assign sim_time_next = sim_time_reg + rrct_pkg::TIME_W'(slice);
    assign waiting_next  = sim_time_next - rrct_pkg::TIME_W'(head.burst);

    always_comb begin
        served = head;
        if (live) begin
            served.rem = head.rem - slice;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sim_time_reg   <= '0;
            done_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (step && live) begin
                if (set_done) begin
                    sim_time_reg   <= '0;
                    done_count_reg <= '0;
                end else begin
                    sim_time_reg <= sim_time_next;
                    if (fin) begin
                        done_count_reg <= done_count_reg + rrct_pkg::CNT_W'(1);
                    end
                end
                if (fin) begin
                    m_valid_reg <= 1'b1;
                end
            end
        end
        if (step && fin) begin
            job_index_reg  <= rrct_pkg::JOB_INDEX_W'(head.idx);
            turnaround_reg <= sim_time_next;
            waiting_reg    <= waiting_next;
            final_reg      <= last_one;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_job_index  = job_index_reg;
    assign m_turnaround = turnaround_reg;
    assign m_waiting    = waiting_reg;
    assign m_final_res  = final_reg;

    `RRCT_ASSERT_NOW(a_done_bound, 1'b1, done_count_reg <= job_count)
    `RRCT_ASSERT_NEXT(a_stall_holds_clock, active && !step, sim_time_reg == $past(sim_time_reg))
    `RRCT_ASSERT_NEXT(a_finish_gives_beat, step && fin, m_valid)

endmodule

// ===== test/rrct_completion_checker.sv =====
// Checker: predicts round-robin completions from accepted beats and compares result beats.
`timescale 1ns / 1ps
module rrct_completion_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rrct_pkg::QUANTUM_W-1:0]   cfg_quantum,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [rrct_pkg::BURST_W-1:0]     s_burst_time,
    input  logic                             s_last,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [rrct_pkg::JOB_INDEX_W-1:0] m_job_index,
    input  logic [rrct_pkg::TIME_W-1:0]      m_turnaround,
    input  logic [rrct_pkg::TIME_W-1:0]      m_waiting,
    input  logic                             m_final_res,
    output int                               fail_count,
    output int                               results_pending
);
    import rrct_pkg::*;

    typedef struct packed {
        logic [JOB_INDEX_W-1:0] job_index;
        logic [TIME_W-1:0]      turnaround;
        logic [TIME_W-1:0]      waiting;
        logic                   final_res;
    } completion_t;

    completion_t          completions_due[$];
    logic [BURST_W-1:0]   burst_of[MAX_JOBS];
    logic [BURST_W-1:0]   left_of[MAX_JOBS];
    int                   jobs_held = 0;
    logic [QUANTUM_W-1:0] slice = QUANTUM_W'(1);
    int                   errs = 0;

    // Store one burst; on a closing beat play the whole set round-robin and
    // queue one completion per job in finishing order.
    task automatic take_burst(input logic [BURST_W-1:0] burst, input logic closes);
        logic [TIME_W-1:0]  clock_now;
        logic [BURST_W-1:0] q;
        int                 finished;
        int                 pos;
        completion_t        c;
        if (burst != 0 && jobs_held < MAX_JOBS) begin
            burst_of[jobs_held] = burst;
            left_of[jobs_held]  = burst;
            jobs_held++;
        end
        if (closes) begin
            q         = (slice == '0) ? QUANTUM_W'(1) : slice;
            clock_now = '0;
            finished  = 0;
            pos       = 0;
            while (finished < jobs_held) begin
                if (left_of[pos] > q) begin
                    clock_now    = clock_now + q;
                    left_of[pos] = left_of[pos] - q;
                end else if (left_of[pos] != 0) begin
                    clock_now    = clock_now + left_of[pos];
                    left_of[pos] = '0;
                    finished++;
                    c.job_index  = pos[JOB_INDEX_W-1:0];
                    c.turnaround = clock_now;
                    c.waiting    = clock_now - burst_of[pos];
                    c.final_res  = (finished == jobs_held);
                    completions_due.push_back(c);
                end
                pos = (pos + 1 < jobs_held) ? pos + 1 : 0;
            end
            jobs_held = 0;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errs++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        completion_t want;
        if (!aresetn) begin
            completions_due.delete();
            jobs_held = 0;
            slice     = QUANTUM_W'(1);
        end else begin
            if (cfg_valid && cfg_ready)
                slice = cfg_quantum;
            if (m_valid && m_ready) begin
                if (completions_due.size() == 0) begin
                    errs++;
                    $display("%0t: result beat expected none, got job_index %0d turnaround %0d",
                             $time, m_job_index, m_turnaround);
                end else begin
                    want = completions_due.pop_front();
                    check_field("job_index", int'(want.job_index), int'(m_job_index));
                    check_field("turnaround", int'(want.turnaround), int'(m_turnaround));
                    check_field("waiting", int'(want.waiting), int'(m_waiting));
                    check_field("final_res", int'(want.final_res), int'(m_final_res));
                end
            end
            if (s_valid && s_ready)
                take_burst(s_burst_time, s_last);
        end
        fail_count      <= errs;
        results_pending <= completions_due.size();
    end

endmodule

// ===== test/tb_round_robin_completion_times.sv =====
// Testbench top: drives burst beats, quantum writes and result back-pressure; gives the verdict.
`timescale 1ns / 1ps
module tb_round_robin_completion_times;
    import rrct_pkg::*;

    // Idle margin before a quantum write, on top of the drain: the block is
    // back in load once the last result beat is taken, so this is slack only.
    localparam int RING_PAUSE  = 2 * MAX_JOBS + 16;
    localparam int RANDOM_JOBS = 200;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [QUANTUM_W-1:0]   cfg_quantum  = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [BURST_W-1:0]     s_burst_time = '0;
    logic                   s_last       = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [JOB_INDEX_W-1:0] m_job_index;
    logic [TIME_W-1:0]      m_turnaround;
    logic [TIME_W-1:0]      m_waiting;
    logic                   m_final_res;
    int                     fail_count;
    int                     results_pending;
    bit                     calm = 1'b0;   // set: no gaps on either side

    round_robin_completion_times uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_quantum  (cfg_quantum),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_burst_time (s_burst_time),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_job_index  (m_job_index),
        .m_turnaround (m_turnaround),
        .m_waiting    (m_waiting),
        .m_final_res  (m_final_res)
    );

    rrct_completion_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_quantum     (cfg_quantum),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_burst_time    (s_burst_time),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_job_index     (m_job_index),
        .m_turnaround    (m_turnaround),
        .m_waiting       (m_waiting),
        .m_final_res     (m_final_res),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: ends the run as a failure if it outlasts the timeout.
    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

    // Gap length in cycles: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Burst sized against the quantum so a set needs at most eight passes of
    // the ring; now and then it lands exactly on the cap (slice boundary or top).
    function automatic logic [BURST_W-1:0] pick_burst(input int q);
        int r;
        int cap;
        int b;
        r   = $urandom_range(0, 9);
        cap = q * ((r < 7) ? $urandom_range(1, 2) : $urandom_range(3, 8));
        if (cap > 65535)
            cap = 65535;
        b = (r == 9) ? cap : $urandom_range(1, cap);
        return b[BURST_W-1:0];
    endfunction

    // Result side back-pressure, independent of the sender.
    initial begin : result_backpressure
        int hold;
        forever begin
            @(posedge aclk);
            hold = idle_len();
            if (hold == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // One burst beat. Valid stays up after acceptance unless a gap follows.
    task automatic send_burst(input logic [BURST_W-1:0] burst, input logic closes);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_burst_time <= burst;
        s_last       <= closes;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until every predicted result beat has been seen.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Quantum write, only once the block has gone idle.
    task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
        drain_results();
        repeat (RING_PAUSE) @(posedge aclk);
        cfg_valid   <= 1'b1;
        cfg_quantum <= q;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int               stored;
        int               n;
        int               b;
        int               q;
        int               phase;
        logic [BURST_W-1:0] burst;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset quantum of one.
        send_burst(16'd1, 1'b1);            // smallest job, alone
        send_burst(16'd3, 1'b0);            // zero burst in the middle gets no index
        send_burst(16'd0, 1'b0);
        send_burst(16'd2, 1'b0);
        send_burst(16'd1, 1'b1);
        send_burst(16'd0, 1'b1);            // empty set: closes with nothing stored
        send_burst(16'd2, 1'b0);            // set closed by a zero burst
        send_burst(16'd0, 1'b1);

        // Largest quantum: top bursts finish in one visit, waiting climbs high.
        write_quantum(16'hFFFF);
        send_burst(16'hFFFF, 1'b0);
        send_burst(16'd1, 1'b0);
        send_burst(16'hFFFF, 1'b1);

        // Quantum 4: exact slice, one over, two slices, short remainder.
        write_quantum(16'd4);
        send_burst(16'd5, 1'b0);
        send_burst(16'd4, 1'b0);
        send_burst(16'd8, 1'b0);
        send_burst(16'd3, 1'b1);

        // Random phases, one quantum each; sets of mixed size, some past the
        // store limit, with occasional zero bursts as noise.
        stored = 0;
        phase  = 0;
        while (stored < RANDOM_JOBS) begin
            case (phase % 5)
                0:       q = 1;
                1:       q = 65535;
                2:       q = $urandom_range(2, 16);
                3:       q = 1 << $urandom_range(0, 15);
                default: q = $urandom_range(1, 65535);
            endcase
            write_quantum(q[QUANTUM_W-1:0]);
            repeat ($urandom_range(3, 6)) begin
                if (stored >= RANDOM_JOBS) break;
                calm = ($urandom_range(0, 4) == 0);
                b    = $urandom_range(0, 9);
                n    = (b < 6) ? $urandom_range(1, 8) :
                       (b < 9) ? $urandom_range(9, 31) : $urandom_range(32, 36);
                for (int i = 0; i < n; i++) begin
                    burst = ($urandom_range(0, 19) == 0) ? '0 : pick_burst(q);
                    if (burst != 0 && i < MAX_JOBS)
                        stored++;
                    send_burst(burst, i == n - 1);
                end
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
            phase++;
        end

        calm = 1'b0;
        drain_results();
        repeat (RING_PAUSE) @(posedge aclk);
        if (fail_count == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rrct_pkg.sv
hdl/rrct_cell.sv
hdl/rrct_serve.sv
hdl/round_robin_completion_times.sv
test/rrct_completion_checker.sv
test/tb_round_robin_completion_times.sv
